/* design/oate_pkg.sv */
// ----------------------------------------------------------------------------
// Ordered array table engine package
// Opcodes, status codes and sequencer states shared by the engine files.
// ----------------------------------------------------------------------------
package oate_pkg;

  localparam int unsigned OpW = 4;
  localparam int unsigned PosW = 8;
  localparam int unsigned DataW = 32;
  localparam int unsigned StatW = 2;
  localparam int unsigned IdxW = 7;
  localparam int unsigned CntW = 8;

  localparam logic [OpW-1:0] OpClear = 4'd0;
  localparam logic [OpW-1:0] OpInsert = 4'd1;
  localparam logic [OpW-1:0] OpEdit = 4'd2;
  localparam logic [OpW-1:0] OpDelete = 4'd3;
  localparam logic [OpW-1:0] OpSortUp = 4'd4;
  localparam logic [OpW-1:0] OpSortDown = 4'd5;
  localparam logic [OpW-1:0] OpFindLin = 4'd6;
  localparam logic [OpW-1:0] OpFindBin = 4'd7;
  localparam logic [OpW-1:0] OpRead = 4'd8;

  localparam logic [StatW-1:0] StOk = 2'd0;
  localparam logic [StatW-1:0] StFull = 2'd1;
  localparam logic [StatW-1:0] StBadPos = 2'd2;
  localparam logic [StatW-1:0] StNotFound = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,   // read entry i-1
    S_INS_WR,   // write it to entry i
    S_DEL_RD,   // read entry i+1
    S_DEL_WR,   // write it to entry i
    S_SRT_RI,   // read entry i
    S_SRT_RJ,   // read entry j
    S_SRT_CMP,  // compare, write back on a swap
    S_SRT_WI,   // write entry i back at the end of a pass
    S_LIN_RD,
    S_LIN_CMP,
    S_BIN_RD,
    S_BIN_CMP,
    S_RD_WAIT,
    S_DONE
  } seq_state_e;

endpackage

/* design/ordered_array_table_engine.sv */
// ----------------------------------------------------------------------------
// Ordered array table engine
// Dense table of signed values held in one synchronous memory, worked on by a
// sequencer that reads, compares and writes back one entry per step.
// ----------------------------------------------------------------------------
// Transfers: one at a time; a new transfer waits until the previous result
//   has been taken, and all table accesses share the single memory port.
// Reset: the count and the sequencer clear at once; the memory is not cleared.
module ordered_array_table_engine #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [oate_pkg::OpW-1:0]            opcode_i,
  input  logic [oate_pkg::PosW-1:0]           position_i,
  input  logic signed [oate_pkg::DataW-1:0]   data_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [oate_pkg::StatW-1:0]          status_o,
  output logic [oate_pkg::IdxW-1:0]           found_index_o,
  output logic signed [oate_pkg::DataW-1:0]   read_data_o,
  output logic [oate_pkg::CntW-1:0]           entry_count_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  // Binary search bounds carry one extra bit for the signed hi of minus one.
  localparam int unsigned BW = CW + 1;
  // Position checks are made wide enough for both the position and the count.
  localparam int unsigned XW = (CW + 1 > oate_pkg::PosW) ? CW + 1 : oate_pkg::PosW;

  typedef logic signed [oate_pkg::DataW-1:0] data_t;

  // The table memory: one port, registered read data.
  data_t           mem_q [DEPTH];
  data_t           rdata_q;
  logic            mem_we;
  logic [AW-1:0]   mem_addr;
  data_t           mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_addr];
  end

  oate_pkg::seq_state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic signed [BW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0] mid;
  logic [oate_pkg::OpW-1:0] op_q, op_d;
  logic [oate_pkg::PosW-1:0] pos_q, pos_d;
  data_t val_q, val_d;
  data_t hold_q, hold_d;  // entry i during a sort

  logic out_valid_q, out_valid_d;
  logic [oate_pkg::StatW-1:0] status_q, status_d;
  logic [oate_pkg::IdxW-1:0] idx_q, idx_d;
  data_t rd_q, rd_d;

  logic accept;
  logic out_free;
  logic [CW:0] pos_ext;
  logic [CW:0] cnt_ext;
  logic swap;
  logic signed [BW:0] mid_wide;

  assign out_free = !out_valid_q || !out_stall_i;
  // A waiting result holds the input off, so the result fields stay put.
  assign in_stall_o = (state_q != oate_pkg::S_IDLE) || out_valid_q;
  assign accept = in_valid_i && !in_stall_o;

  assign pos_ext = (CW + 1)'(pos_q);
  assign cnt_ext = (CW + 1)'(count_q);
  assign mid_wide = ((BW + 1)'(lo_q) + (BW + 1)'(hi_q)) >>> 1;
  assign mid = mid_wide[CW-1:0];
  assign swap = (op_q == oate_pkg::OpSortDown) ? (hold_q < rdata_q)
                                               : (hold_q > rdata_q);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    i_d = i_q;
    j_d = j_q;
    lo_d = lo_q;
    hi_d = hi_q;
    op_d = op_q;
    pos_d = pos_q;
    val_d = val_q;
    hold_d = hold_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d = status_q;
    idx_d = idx_q;
    rd_d = rd_q;
    mem_we = 1'b0;
    mem_addr = i_q[AW-1:0];
    mem_wdata = hold_q;

    case (state_q)
      oate_pkg::S_IDLE: begin
        if (accept) begin
          op_d = opcode_i;
          pos_d = position_i;
          val_d = data_value_i;
          status_d = oate_pkg::StOk;
          idx_d = '0;
          rd_d = '0;
          state_d = oate_pkg::S_DONE;
          case (opcode_i)
            oate_pkg::OpClear: count_d = '0;
            oate_pkg::OpInsert: begin
              if (XW'(position_i) > XW'(count_q)) begin
                status_d = oate_pkg::StBadPos;
              end else if ((CW + 1)'(count_q) >= (CW + 1)'(DEPTH)) begin
                status_d = oate_pkg::StFull;
              end else begin
                i_d = count_q;
                state_d = oate_pkg::S_INS_RD;
              end
            end
            oate_pkg::OpEdit, oate_pkg::OpDelete, oate_pkg::OpRead: begin
              if (XW'(position_i) >= XW'(count_q)) begin
                status_d = oate_pkg::StBadPos;
              end else begin
                i_d = CW'(position_i);
                case (opcode_i)
                  oate_pkg::OpEdit: state_d = oate_pkg::S_DONE;
                  oate_pkg::OpDelete: state_d = oate_pkg::S_DEL_RD;
                  default: begin
                    // Start the read now so the data lands in S_RD_WAIT.
                    mem_addr = AW'(position_i);
                    state_d = oate_pkg::S_RD_WAIT;
                  end
                endcase
              end
            end
            oate_pkg::OpSortUp, oate_pkg::OpSortDown: begin
              i_d = '0;
              state_d = oate_pkg::S_SRT_RI;
            end
            oate_pkg::OpFindLin: begin
              i_d = '0;
              status_d = oate_pkg::StNotFound;
              state_d = oate_pkg::S_LIN_RD;
            end
            oate_pkg::OpFindBin: begin
              lo_d = '0;
              hi_d = BW'(count_q) - BW'(1);
              status_d = oate_pkg::StNotFound;
              state_d = oate_pkg::S_BIN_RD;
            end
            default: ;
          endcase
        end
      end

      oate_pkg::S_INS_RD: begin
        // Entry i takes entry i-1 until i reaches the position.
        if ((CW + 1)'(i_q) > pos_ext) begin
          mem_addr = AW'(i_q - CW'(1));
          state_d = oate_pkg::S_INS_WR;
        end else begin
          mem_we = 1'b1;
          mem_wdata = val_q;
          count_d = count_q + CW'(1);
          state_d = oate_pkg::S_DONE;
        end
      end

      oate_pkg::S_INS_WR: begin
        mem_we = 1'b1;
        mem_wdata = rdata_q;
        i_d = i_q - CW'(1);
        state_d = oate_pkg::S_INS_RD;
      end

      oate_pkg::S_DEL_RD: begin
        if ((CW + 1)'(i_q) + (CW + 1)'(1) < cnt_ext) begin
          mem_addr = AW'(i_q + CW'(1));
          state_d = oate_pkg::S_DEL_WR;
        end else begin
          count_d = count_q - CW'(1);
          state_d = oate_pkg::S_DONE;
        end
      end

      oate_pkg::S_DEL_WR: begin
        mem_we = 1'b1;
        mem_wdata = rdata_q;
        i_d = i_q + CW'(1);
        state_d = oate_pkg::S_DEL_RD;
      end

      oate_pkg::S_SRT_RI: begin
        if ((CW + 1)'(i_q) + (CW + 1)'(1) < cnt_ext) begin
          mem_addr = i_q[AW-1:0];
          j_d = i_q + CW'(1);
          state_d = oate_pkg::S_SRT_RJ;
        end else begin
          state_d = oate_pkg::S_DONE;
        end
      end

      oate_pkg::S_SRT_RJ: begin
        // Entry i was read last cycle unless a compare just refreshed it.
        if (j_q == i_q + CW'(1)) begin
          hold_d = rdata_q;
        end
        mem_addr = j_q[AW-1:0];
        state_d = oate_pkg::S_SRT_CMP;
      end

      oate_pkg::S_SRT_CMP: begin
        if (swap) begin
          mem_we = 1'b1;
          mem_addr = j_q[AW-1:0];
          mem_wdata = hold_q;
          hold_d = rdata_q;
        end
        if ((CW + 1)'(j_q) + (CW + 1)'(1) < cnt_ext) begin
          j_d = j_q + CW'(1);
          state_d = oate_pkg::S_SRT_RJ;
        end else begin
          // Entry i is written back at the end of the pass, held in hold_q.
          state_d = oate_pkg::S_SRT_WI;
        end
      end

      oate_pkg::S_SRT_WI: begin
        mem_we = 1'b1;
        mem_wdata = hold_q;
        i_d = i_q + CW'(1);
        state_d = oate_pkg::S_SRT_RI;
      end

      oate_pkg::S_LIN_RD: begin
        if (i_q < count_q) begin
          mem_addr = i_q[AW-1:0];
          state_d = oate_pkg::S_LIN_CMP;
        end else begin
          state_d = oate_pkg::S_DONE;
        end
      end

      oate_pkg::S_LIN_CMP: begin
        if (rdata_q == val_q) begin
          status_d = oate_pkg::StOk;
          idx_d = oate_pkg::IdxW'(i_q);
          state_d = oate_pkg::S_DONE;
        end else begin
          i_d = i_q + CW'(1);
          state_d = oate_pkg::S_LIN_RD;
        end
      end

      oate_pkg::S_BIN_RD: begin
        if (lo_q <= hi_q) begin
          mem_addr = mid[AW-1:0];
          i_d = mid;
          state_d = oate_pkg::S_BIN_CMP;
        end else begin
          state_d = oate_pkg::S_DONE;
        end
      end

      oate_pkg::S_BIN_CMP: begin
        if (rdata_q == val_q) begin
          status_d = oate_pkg::StOk;
          idx_d = oate_pkg::IdxW'(i_q);
          state_d = oate_pkg::S_DONE;
        end else begin
          if (rdata_q < val_q) begin
            lo_d = BW'(i_q) + BW'(1);
          end else begin
            hi_d = BW'(i_q) - BW'(1);
          end
          state_d = oate_pkg::S_BIN_RD;
        end
      end

      oate_pkg::S_RD_WAIT: begin
        rd_d = rdata_q;
        state_d = oate_pkg::S_DONE;
      end

      oate_pkg::S_DONE: begin
        if (op_q == oate_pkg::OpEdit && status_q == oate_pkg::StOk && !out_valid_q) begin
          mem_we = 1'b1;
          mem_addr = i_q[AW-1:0];
          mem_wdata = val_q;
        end
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d = oate_pkg::S_IDLE;
        end
      end

      default: state_d = oate_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oate_pkg::S_IDLE;
      count_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and loop registers.
  always_ff @(posedge clk_i) begin
    j_q <= j_d;
    lo_q <= lo_d;
    hi_q <= hi_d;
    op_q <= op_d;
    pos_q <= pos_d;
    val_q <= val_d;
    hold_q <= hold_d;
    status_q <= status_d;
    idx_q <= idx_d;
    rd_q <= rd_d;
    i_q <= i_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign found_index_o = idx_q;
  assign read_data_o = rd_q;
  assign entry_count_o = oate_pkg::CntW'(count_q);

endmodule

/* design/oate_checker.sv */
// ----------------------------------------------------------------------------
// Ordered array table engine checker
// Port-level checks on the engine handshake and result fields.
// ----------------------------------------------------------------------------
module oate_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [oate_pkg::StatW-1:0]    status_o,
  input logic [oate_pkg::IdxW-1:0]     found_index_o,
  input logic [oate_pkg::OpW-1:0]      opcode_i
);

  // A stalled result holds its valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A search that misses reports index zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == oate_pkg::StNotFound |-> found_index_o == '0)
    else $error("miss with non-zero index");

  // A transfer in makes the engine busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("engine not busy after transfer");

  // A clear never reports an error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && opcode_i == oate_pkg::OpClear |=> ##1
    (out_valid_o && status_o == oate_pkg::StOk))
    else $error("clear result wrong");

endmodule

bind ordered_array_table_engine oate_checker u_oate_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .in_valid_i(in_valid_i),
  .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .status_o(status_o),
  .found_index_o(found_index_o),
  .opcode_i(opcode_i)
);

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// Ordered array table engine testbench
// Drives the engine through a table of directed operations and then a long
// run of random ones, with a table fill halfway, random input gaps and output
// stalls. A predictor keeps its own copy of the table, and every result
// transfer is checked field by field against the oldest expected answer.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned TblDepth = 128;
  localparam int unsigned RandItems = 550;
  localparam int unsigned CycleLimit = 2000000;

  // One predicted or observed answer of the engine.
  typedef struct packed {
    logic [oate_pkg::StatW-1:0]        status;
    logic [oate_pkg::IdxW-1:0]         idx;
    logic signed [oate_pkg::DataW-1:0] rdata;
    logic [oate_pkg::CntW-1:0]         cnt;
  } answer_t;

  // One row of the directed table. Where known is set, the answer is typed in
  // and used in place of the predictor's; the predictor still advances.
  typedef struct {
    logic [oate_pkg::OpW-1:0]          op;
    logic [oate_pkg::PosW-1:0]         pos;
    logic signed [oate_pkg::DataW-1:0] data;
    bit                                known;
    answer_t                           ans;
  } directed_row_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [oate_pkg::OpW-1:0]          opcode = '0;
  logic [oate_pkg::PosW-1:0]         position = '0;
  logic signed [oate_pkg::DataW-1:0] data_value = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [oate_pkg::StatW-1:0]        status;
  logic [oate_pkg::IdxW-1:0]         found_index;
  logic signed [oate_pkg::DataW-1:0] read_data;
  logic [oate_pkg::CntW-1:0]         entry_count;

  // Predictor state: its own copy of the table and the count.
  int signed   shadow_tbl [TblDepth];
  int unsigned shadow_count;

  answer_t     pending_answers [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;

  ordered_array_table_engine #(
    .DEPTH(TblDepth)
  ) u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .opcode_i      (opcode),
    .position_i    (position),
    .data_value_i  (data_value),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .found_index_o (found_index),
    .read_data_o   (read_data),
    .entry_count_o (entry_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Works out the answer to one operation and applies it to the shadow table.
  function automatic answer_t table_answer(logic [oate_pkg::OpW-1:0] op,
                                           logic [oate_pkg::PosW-1:0] pos,
                                           logic signed [oate_pkg::DataW-1:0] val);
    answer_t     a;
    int signed   lo;
    int signed   hi;
    int signed   mid;
    int signed   tmp;
    bit          swap;
    bit          hit;
    int unsigned p;
    a = '0;
    p = 32'(pos);
    hit = 1'b0;
    case (op)
      oate_pkg::OpClear: shadow_count = 0;
      oate_pkg::OpInsert: begin
        // A position beyond the count is refused before a full table is.
        if (p > shadow_count) a.status = oate_pkg::StBadPos;
        else if (shadow_count >= TblDepth) a.status = oate_pkg::StFull;
        else begin
          for (int i = shadow_count; i > p; i--) shadow_tbl[i] = shadow_tbl[i-1];
          shadow_tbl[p] = val;
          shadow_count++;
        end
      end
      oate_pkg::OpEdit: begin
        if (p >= shadow_count) a.status = oate_pkg::StBadPos;
        else shadow_tbl[p] = val;
      end
      oate_pkg::OpDelete: begin
        if (p >= shadow_count) a.status = oate_pkg::StBadPos;
        else begin
          for (int i = p; i + 1 < shadow_count; i++) shadow_tbl[i] = shadow_tbl[i+1];
          shadow_count--;
        end
      end
      oate_pkg::OpSortUp, oate_pkg::OpSortDown: begin
        for (int i = 0; i + 1 < shadow_count; i++) begin
          for (int j = i + 1; j < shadow_count; j++) begin
            swap = (op == oate_pkg::OpSortDown) ? (shadow_tbl[i] < shadow_tbl[j])
                                                : (shadow_tbl[i] > shadow_tbl[j]);
            if (swap) begin
              tmp = shadow_tbl[i];
              shadow_tbl[i] = shadow_tbl[j];
              shadow_tbl[j] = tmp;
            end
          end
        end
      end
      oate_pkg::OpFindLin: begin
        for (int i = 0; i < shadow_count && !hit; i++) begin
          if (shadow_tbl[i] == val) begin
            hit = 1'b1;
            a.idx = i[oate_pkg::IdxW-1:0];
          end
        end
        if (!hit) a.status = oate_pkg::StNotFound;
      end
      oate_pkg::OpFindBin: begin
        // Halving runs as written, sorted table or not.
        lo = 0;
        hi = int'(shadow_count) - 1;
        while (lo <= hi && !hit) begin
          mid = lo + (hi - lo) / 2;
          if (shadow_tbl[mid] == val) begin
            hit = 1'b1;
            a.idx = mid[oate_pkg::IdxW-1:0];
          end else if (shadow_tbl[mid] < val) lo = mid + 1;
          else hi = mid - 1;
        end
        if (!hit) a.status = oate_pkg::StNotFound;
      end
      oate_pkg::OpRead: begin
        if (p >= shadow_count) a.status = oate_pkg::StBadPos;
        else a.rdata = shadow_tbl[p];
      end
      default: ;
    endcase
    a.cnt = shadow_count[oate_pkg::CntW-1:0];
    return a;
  endfunction

  // Presents one operation and holds it until the transfer completes. Gaps of
  // random length fall between bursts of random length.
  task automatic send_op(logic [oate_pkg::OpW-1:0] op, logic [oate_pkg::PosW-1:0] pos,
                         logic signed [oate_pkg::DataW-1:0] val, bit known,
                         answer_t typed);
    int unsigned gap;
    answer_t     predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    opcode     <= op;
    position   <= pos;
    data_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = table_answer(op, pos, val);
    pending_answers.push_back(known ? typed : predicted);
  endtask

  function automatic logic signed [oate_pkg::DataW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return $urandom();
      default: return $signed($urandom_range(0, 16)) - 8;
    endcase
  endfunction

  // Mostly valid positions, now and then anything the field can carry.
  function automatic logic [oate_pkg::PosW-1:0] pick_pos(int unsigned limit);
    if ($urandom_range(0, 9) == 0) return oate_pkg::PosW'($urandom_range(0, 255));
    return oate_pkg::PosW'($urandom_range(0, limit));
  endfunction

  // Fills the table to the top, knocks on the full table and works on it, then clears it.
  task automatic fill_table();
    while (shadow_count < TblDepth)
      send_op(oate_pkg::OpInsert, pick_pos(shadow_count), pick_value(), 1'b0, '0);
    send_op(oate_pkg::OpInsert, 8'd0, pick_value(), 1'b1,
            '{oate_pkg::StFull, 7'd0, 32'sd0, 8'd128});
    send_op(oate_pkg::OpInsert, 8'd128, pick_value(), 1'b1,
            '{oate_pkg::StFull, 7'd0, 32'sd0, 8'd128});
    send_op(oate_pkg::OpInsert, 8'd129, pick_value(), 1'b1,
            '{oate_pkg::StBadPos, 7'd0, 32'sd0, 8'd128});
    send_op(oate_pkg::OpRead, 8'd127, '0, 1'b0, '0);
    send_op(oate_pkg::OpRead, 8'd128, '0, 1'b1,
            '{oate_pkg::StBadPos, 7'd0, 32'sd0, 8'd128});
    send_op(oate_pkg::OpFindLin, '0, pick_value(), 1'b0, '0);
    send_op(oate_pkg::OpFindBin, '0, pick_value(), 1'b0, '0);
    send_op(oate_pkg::OpEdit, 8'd127, pick_value(), 1'b0, '0);
    send_op(oate_pkg::OpDelete, 8'd127, '0, 1'b0, '0);
    send_op(oate_pkg::OpInsert, 8'd127, pick_value(), 1'b0, '0);
    send_op(oate_pkg::OpSortDown, '0, '0, 1'b0, '0);
    send_op(oate_pkg::OpFindBin, '0, pick_value(), 1'b0, '0);
    send_op(oate_pkg::OpClear, '0, '0, 1'b1, '{oate_pkg::StOk, 7'd0, 32'sd0, 8'd0});
  endtask

  task automatic random_op();
    int unsigned              w;
    logic [oate_pkg::OpW-1:0] op;
    w = $urandom_range(0, 99);
    if (w < 30) op = oate_pkg::OpInsert;
    else if (w < 44) op = oate_pkg::OpDelete;
    else if (w < 53) op = oate_pkg::OpEdit;
    else if (w < 58) op = oate_pkg::OpSortUp;
    else if (w < 62) op = oate_pkg::OpSortDown;
    else if (w < 72) op = oate_pkg::OpFindLin;
    else if (w < 82) op = oate_pkg::OpFindBin;
    else if (w < 95) op = oate_pkg::OpRead;
    else if (w < 97) op = oate_pkg::OpClear;
    else op = oate_pkg::OpW'($urandom_range(9, 15));
    // Sorts are slow on a long table, so above 40 entries a read is sent in their place.
    if ((op == oate_pkg::OpSortUp || op == oate_pkg::OpSortDown) && shadow_count > 40)
      op = oate_pkg::OpRead;
    // Searches pick a stored value most of the time, so that hits are common.
    if ((op == oate_pkg::OpFindLin || op == oate_pkg::OpFindBin) && shadow_count > 0 &&
        $urandom_range(0, 2) != 0)
      send_op(op, pick_pos(shadow_count), shadow_tbl[$urandom_range(0, shadow_count - 1)],
              1'b0, '0);
    else
      send_op(op, pick_pos(shadow_count), pick_value(), 1'b0, '0);
  endtask

  // Stimulus: directed table first, then the random run.
  initial begin
    directed_row_t rows [$];
    shadow_count = 0;
    rows = '{
      '{oate_pkg::OpRead, 8'd0, 32'sd0, 1'b1, '{oate_pkg::StBadPos, 7'd0, 32'sd0, 8'd0}},
      '{oate_pkg::OpDelete, 8'd0, 32'sd0, 1'b1, '{oate_pkg::StBadPos, 7'd0, 32'sd0, 8'd0}},
      '{oate_pkg::OpEdit, 8'd0, 32'sd7, 1'b1, '{oate_pkg::StBadPos, 7'd0, 32'sd0, 8'd0}},
      '{oate_pkg::OpFindLin, 8'd0, 32'sd5, 1'b1,
        '{oate_pkg::StNotFound, 7'd0, 32'sd0, 8'd0}},
      '{oate_pkg::OpFindBin, 8'd0, 32'sd5, 1'b1,
        '{oate_pkg::StNotFound, 7'd0, 32'sd0, 8'd0}},
      '{oate_pkg::OpInsert, 8'd1, 32'sd5, 1'b1, '{oate_pkg::StBadPos, 7'd0, 32'sd0, 8'd0}},
      '{oate_pkg::OpInsert, 8'd0, 32'sh7fffffff, 1'b1,
        '{oate_pkg::StOk, 7'd0, 32'sd0, 8'd1}},
      '{oate_pkg::OpInsert, 8'd0, 32'sh80000000, 1'b1,
        '{oate_pkg::StOk, 7'd0, 32'sd0, 8'd2}},
      '{oate_pkg::OpInsert, 8'd2, 32'sd0, 1'b1, '{oate_pkg::StOk, 7'd0, 32'sd0, 8'd3}},
      '{oate_pkg::OpRead, 8'd0, 32'sd0, 1'b1,
        '{oate_pkg::StOk, 7'd0, 32'sh80000000, 8'd3}},
      '{oate_pkg::OpRead, 8'd2, 32'sd0, 1'b1, '{oate_pkg::StOk, 7'd0, 32'sd0, 8'd3}},
      '{oate_pkg::OpInsert, 8'd255, 32'sd1, 1'b1,
        '{oate_pkg::StBadPos, 7'd0, 32'sd0, 8'd3}},
      '{oate_pkg::OpSortDown, 8'd0, 32'sd0, 1'b0, '0},
      '{oate_pkg::OpRead, 8'd0, 32'sd0, 1'b0, '0},
      '{oate_pkg::OpSortUp, 8'd0, 32'sd0, 1'b0, '0},
      '{oate_pkg::OpFindBin, 8'd0, 32'sh7fffffff, 1'b0, '0},
      '{oate_pkg::OpFindLin, 8'd0, -32'sd1, 1'b1,
        '{oate_pkg::StNotFound, 7'd0, 32'sd0, 8'd3}},
      '{oate_pkg::OpEdit, 8'd1, -32'sd5, 1'b0, '0},
      '{oate_pkg::OpDelete, 8'd0, 32'sd0, 1'b0, '0},
      '{oate_pkg::OpRead, 8'd3, 32'sd0, 1'b1, '{oate_pkg::StBadPos, 7'd0, 32'sd0, 8'd2}},
      '{4'd9, 8'd0, 32'sd9, 1'b1, '{oate_pkg::StOk, 7'd0, 32'sd0, 8'd2}},
      '{4'd15, 8'd255, -32'sd1, 1'b1, '{oate_pkg::StOk, 7'd0, 32'sd0, 8'd2}},
      '{oate_pkg::OpSortUp, 8'd0, 32'sd0, 1'b0, '0},
      '{oate_pkg::OpDelete, 8'd1, 32'sd0, 1'b0, '0},
      '{oate_pkg::OpClear, 8'd0, 32'sd0, 1'b1, '{oate_pkg::StOk, 7'd0, 32'sd0, 8'd0}}
    };
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[k]) send_op(rows[k].op, rows[k].pos, rows[k].data, rows[k].known,
                              rows[k].ans);
    for (int n = 0; n < RandItems; n++) begin
      if (n == RandItems / 2) fill_table();
      random_op();
    end
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  // Receiver: the stall pattern steps through four modes in turn, set by bits 9:8 of the cycle count:
  // no stall at all, random stalls, a fixed duty cycle, and rarer random stalls.
  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    cycle_count <= cycle_count + 1;
    case (cycle_count[9:8])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 2) == 0);
      2'd2: out_stall <= (cycle_count[2:0] < 3'd5);
      default: out_stall <= ($urandom_range(0, 9) == 0);
    endcase
    if (rst_n && out_valid && !out_stall) begin
      got = '{status, found_index, read_data, entry_count};
      if (pending_answers.size() == 0) begin
        $display("%0t: result transfer with nothing expected: %p", $time, got);
        error_count++;
      end else begin
        want = pending_answers.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
          error_count++;
        end
        if (got.idx !== want.idx) begin
          $display("%0t: found_index expected %0d, actual %0d", $time, want.idx, got.idx);
          error_count++;
        end
        if (got.rdata !== want.rdata) begin
          $display("%0t: read_data expected %0d, actual %0d", $time, want.rdata, got.rdata);
          error_count++;
        end
        if (got.cnt !== want.cnt) begin
          $display("%0t: entry_count expected %0d, actual %0d", $time, want.cnt, got.cnt);
          error_count++;
        end
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout", $time);
      $display("testbench: errors");
      $finish;
    end
  end

endmodule

/* sim.f */
design/oate_pkg.sv
design/ordered_array_table_engine.sv
design/oate_checker.sv
tb/sv/testbench.sv
